/* sv/dkhc_pkg.sv */
// Shared types and constants for the diagonal k-mer hit chainer.
`default_nettype none

package dkhc_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 4;
	localparam logic [CFG_INDEX_W-1:0] CFG_KMER_LENGTH         = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CONNECT_DISTANCE    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_FRAGMENT_LENGTH = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_QUERY_LENGTH        = 4'd3;

	// Register reset values
	localparam logic [6:0]  KMER_LENGTH_RST         = 7'd16;
	localparam logic [15:0] CONNECT_DISTANCE_RST    = 16'd100;
	localparam logic [31:0] MIN_FRAGMENT_LENGTH_RST = 32'd20;
	localparam logic [31:0] QUERY_LENGTH_RST        = 32'd0;

	// Identity scale (percent times 100) and quotient width
	localparam int          IDENT_SCALE_W = 14;
	localparam logic [13:0] IDENT_SCALE   = 14'd10000;
	localparam int          DIV_STEPS     = 16;

	// Fragment queue depth, power of two
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic signed [31:0] diagonal;
		logic [15:0]        subject_id;
		logic [31:0]        subject_pos;
		logic               reverse_strand;
		logic               group_last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] query_start;
		logic [31:0] query_end;
		logic [15:0] out_subject_id;
		logic [31:0] subject_start;
		logic [31:0] subject_end;
		logic        out_reverse;
		logic [31:0] chain_score;
		logic [15:0] identity_x100;
	} out_item_t;

	typedef struct packed {
		logic [6:0]  kmer_length;
		logic [15:0] connect_distance;
		logic [31:0] min_fragment_length;
		logic [31:0] query_length;
	} cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SCALE,
		BK_CHECK,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

/* sv/dkhc_front.sv */
// Front end: chains hits along diagonals and queues fragment candidates.
`default_nettype none

module dkhc_front
	import dkhc_pkg::*;
#(
	parameter int POS_BITS = 32,
	parameter int ENT_W = 2 * POS_BITS + 81
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire in_item_t         in_data,
	input  wire cfg_t             cfg,
	output logic                  push,
	output logic [ENT_W-1:0]      push_data
);

	logic                have_prev_q, chain_active_q;
	logic [1:0]          gc_q;
	logic [31:0]         prev_diag_q, chain_diag_q, score_q;
	logic [15:0]         prev_subj_q;
	logic [POS_BITS-1:0] prev_pos_q, chain_first_q, chain_last_q;

	logic                have_prev_n, active_n;
	logic [1:0]          gc_inc, gc_n;
	logic [31:0]         diag, diag_n, score_n;
	logic [POS_BITS-1:0] pos, first_n, last_n;
	logic                reach, link, emit_brk, emit_end;

	// Chain decision for the presented hit
	always_comb begin
		pos      = POS_BITS'(in_data.subject_pos);
		diag     = in_data.diagonal;
		reach    = ({1'b0, prev_pos_q} + (POS_BITS+1)'(cfg.connect_distance)) >= {1'b0, pos};
		link     = have_prev_q && (prev_diag_q == diag) &&
		           (prev_subj_q == in_data.subject_id) && reach;
		active_n = chain_active_q;
		diag_n   = chain_diag_q;
		first_n  = chain_first_q;
		last_n   = chain_last_q;
		score_n  = score_q;
		emit_brk = 1'b0;
		if (!have_prev_q) begin
			active_n = 1'b0;
			gc_inc   = 2'd1;
		end else begin
			gc_inc = (gc_q == 2'd3) ? 2'd3 : gc_q + 2'd1;
			if (link) begin
				last_n = pos;
				if (chain_active_q) begin
					if (score_q != '1) score_n = score_q + 32'd1;
				end else begin
					active_n = 1'b1;
					diag_n   = prev_diag_q;
					first_n  = prev_pos_q;
					score_n  = 32'd1;
				end
			end else if (chain_active_q) begin
				emit_brk = 1'b1;
				active_n = 1'b0;
			end
		end
		// End of group closes any open chain
		emit_end    = in_data.group_last && active_n;
		have_prev_n = !in_data.group_last;
		gc_n        = in_data.group_last ? 2'd0 : gc_inc;
		if (in_data.group_last) active_n = 1'b0;
	end

	// Candidate request; the back end applies the span test
	always_comb begin
		push = accept && (emit_brk || emit_end) && (gc_inc == 2'd3);
		if (emit_brk) begin
			push_data = {in_data.reverse_strand, prev_subj_q, score_q, chain_diag_q,
			             chain_last_q, chain_first_q};
		end else begin
			push_data = {in_data.reverse_strand, in_data.subject_id, score_n, diag_n,
			             last_n, first_n};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q    <= 1'b0;
			chain_active_q <= 1'b0;
			gc_q           <= 2'd0;
		end else if (accept) begin
			have_prev_q    <= have_prev_n;
			chain_active_q <= active_n;
			gc_q           <= gc_n;
		end
	end

	// Hit and chain payload
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_diag_q   <= diag;
			prev_subj_q   <= in_data.subject_id;
			prev_pos_q    <= pos;
			chain_diag_q  <= diag_n;
			chain_first_q <= first_n;
			chain_last_q  <= last_n;
			score_q       <= score_n;
		end
	end

endmodule

`default_nettype wire

/* sv/dkhc_queue.sv */
// Short FIFO of fragment candidates between front and back end.
`default_nettype none

module dkhc_queue
	import dkhc_pkg::*;
#(
	parameter int WIDTH = 145
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output q_status_t             status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign head         = slot_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

/* sv/dkhc_back.sv */
// Back end: span test, coordinates and identity division for each candidate.
`default_nettype none

module dkhc_back
	import dkhc_pkg::*;
#(
	parameter int POS_BITS = 32,
	parameter int ENT_W = 2 * POS_BITS + 81
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [ENT_W-1:0] head,
	input  wire q_status_t        q_stat,
	input  wire cfg_t             cfg,
	output logic                  pop,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output out_item_t             out_data
);

	localparam int CW     = ((POS_BITS > 32) ? POS_BITS : 32) + 2;
	localparam int DEN_W  = POS_BITS + 1;
	localparam int PROD_W = 32 + 7;
	localparam int NUM_W  = PROD_W + IDENT_SCALE_W;
	localparam int CMP_W  = (NUM_W > DEN_W + DIV_STEPS) ? NUM_W : DEN_W + DIV_STEPS;
	localparam int CNT_W  = $clog2(DIV_STEPS);

	back_state_t state_q, state_n;

	// Unpacked head entry
	logic                h_rev;
	logic [15:0]         h_subj;
	logic [31:0]         h_score, h_diag;
	logic [POS_BITS-1:0] h_last, h_first;
	assign {h_rev, h_subj, h_score, h_diag, h_last, h_first} = head;

	logic                rev_q;
	logic [15:0]         subj_q;
	logic [31:0]         score_q, diag_q;
	logic [POS_BITS-1:0] last_q, first_q;

	logic [PROD_W-1:0]   prod_q;
	logic [NUM_W-1:0]    num_q;
	logic [DEN_W-1:0]    denom_q;
	logic [CW-1:0]       ek_q, s1m_q;
	logic                pass_q;
	logic [31:0]         qs_q, qe_q, ss_q, se_q;
	logic [CMP_W-1:0]    rem_q, dvs_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [31:0]         s32, e32, k32;
	logic                sat, ge, out_free, out_load;

	assign s32      = 32'(first_q);
	assign e32      = 32'(last_q);
	assign k32      = 32'(cfg.kmer_length);
	assign sat      = CMP_W'(num_q) >= (CMP_W'(denom_q) << DIV_STEPS);
	assign ge       = rem_q >= dvs_q;
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			BK_IDLE:  if (!q_stat.empty) state_n = BK_MUL;
			BK_MUL:   state_n = BK_SCALE;
			BK_SCALE: state_n = BK_CHECK;
			BK_CHECK: begin
				if (!pass_q)  state_n = BK_IDLE;
				else if (sat) state_n = BK_DONE;
				else          state_n = BK_DIV;
			end
			BK_DIV:   if (cnt_q == '0) state_n = BK_DONE;
			BK_DONE:  if (out_free) state_n = BK_IDLE;
			default:  state_n = BK_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop      = (state_q == BK_IDLE) && !q_stat.empty;
		out_load = (state_q == BK_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Datapath, one step per state
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop) begin
					rev_q   <= h_rev;
					subj_q  <= h_subj;
					score_q <= h_score;
					diag_q  <= h_diag;
					last_q  <= h_last;
					first_q <= h_first;
				end
			end
			BK_MUL: begin
				prod_q  <= PROD_W'(score_q) * PROD_W'(cfg.kmer_length);
				ek_q    <= CW'(last_q) + CW'(cfg.kmer_length);
				s1m_q   <= CW'(first_q) + CW'(cfg.min_fragment_length) + CW'(1);
				denom_q <= DEN_W'(last_q) + DEN_W'(cfg.kmer_length) - DEN_W'(first_q)
				           + DEN_W'(1);
				if (rev_q) begin
					qs_q <= cfg.query_length - (diag_q + s32);
					qe_q <= cfg.query_length - (diag_q + e32) - k32 + 32'd1;
				end else begin
					qs_q <= diag_q + s32 + 32'd1;
					qe_q <= diag_q + e32 + k32;
				end
				ss_q <= s32 + 32'd1;
				se_q <= e32 + k32;
			end
			BK_SCALE: begin
				num_q  <= NUM_W'(prod_q) * NUM_W'(IDENT_SCALE);
				pass_q <= ek_q >= s1m_q;
			end
			BK_CHECK: begin
				rem_q <= CMP_W'(num_q);
				dvs_q <= CMP_W'(denom_q) << (DIV_STEPS - 1);
				quo_q <= sat ? '1 : '0;
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end
			BK_DIV: begin
				// Restoring division, one quotient bit per cycle
				if (ge) rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[DIV_STEPS-2:0], ge};
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			BK_DONE: begin
				if (out_load) begin
					out_q.query_start    <= qs_q;
					out_q.query_end      <= qe_q;
					out_q.out_subject_id <= subj_q;
					out_q.subject_start  <= ss_q;
					out_q.subject_end    <= se_q;
					out_q.out_reverse    <= rev_q;
					out_q.chain_score    <= score_q;
					out_q.identity_x100  <= quo_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

/* sv/diagonal_kmer_hit_chainer.sv */
// Top level of the diagonal k-mer hit chainer.
// The front end takes one hit per cycle and links it to the previous hit of the
// same diagonal and subject; it stalls only while the four-entry fragment queue
// is full. Each queued chain end passes the back end through pop, multiply, scale
// and check, and stops there if its span is below the minimum; it goes on to output
// load if identity saturates, else after 16 divide steps; the serial identity
// divider sets the fragment rate. Fragments leave through an output register, so
// the back end starts the next candidate while a result waits. Configuration
// writes are always ready and take effect at once; write them only when idle.
`default_nettype none

module diagonal_kmer_hit_chainer
	import dkhc_pkg::*;
#(
	parameter int POS_BITS = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire in_item_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output out_item_t                   out_data,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data
);

	localparam int ENT_W = 2 * POS_BITS + 81;

	cfg_t             cfg_q;
	q_status_t        q_stat;
	logic             accept, push, pop;
	logic [ENT_W-1:0] push_data, head;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_stat.full;
	assign accept    = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kmer_length         <= KMER_LENGTH_RST;
			cfg_q.connect_distance    <= CONNECT_DISTANCE_RST;
			cfg_q.min_fragment_length <= MIN_FRAGMENT_LENGTH_RST;
			cfg_q.query_length        <= QUERY_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KMER_LENGTH:         cfg_q.kmer_length         <= cfg_data[6:0];
				CFG_CONNECT_DISTANCE:    cfg_q.connect_distance    <= cfg_data[15:0];
				CFG_MIN_FRAGMENT_LENGTH: cfg_q.min_fragment_length <= cfg_data;
				CFG_QUERY_LENGTH:        cfg_q.query_length        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dkhc_front #(
		.POS_BITS (POS_BITS),
		.ENT_W    (ENT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.push      (push),
		.push_data (push_data)
	);

	dkhc_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_stat)
	);

	dkhc_back #(
		.POS_BITS (POS_BITS),
		.ENT_W    (ENT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.cfg       (cfg_q),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

/* sv/dkhc_checker.sv */
// Port-level checks for the chainer, bound to its top level.
`default_nettype none

module dkhc_checker
	import dkhc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire in_item_t               in_data,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire out_item_t              out_data,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [31:0]            cfg_data
);

	// A stalled fragment stays offered unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("fragment changed while stalled");

	// Every emitted chain links at least one hit pair
	a_score_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.chain_score != 32'd0)
		else $error("fragment with zero score");

	// Register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind diagonal_kmer_hit_chainer dkhc_checker u_dkhc_checker (.*);

`default_nettype wire

/* sim/dkhc_checker.sv */
// Fragment predictor and output comparator for the diagonal k-mer hit chainer.
module dkhc_scoreboard
	import dkhc_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire in_item_t               in_data,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire out_item_t              out_data,
	input  wire logic                   cfg_valid,
	input  wire logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data,
	output int                          fail_count,
	output int                          pending,
	output int                          frags_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] PERCENT_X100 = 64'd10000;

	// Shadow of the configuration registers
	logic [6:0]  k_len;
	logic [15:0] link_dist;
	logic [31:0] min_span;
	logic [31:0] qry_len;

	// Shadow of the chaining state
	logic        have_prev;
	logic [31:0] prev_diag;
	logic [15:0] prev_subj;
	logic [31:0] prev_pos;
	logic        chain_on;
	logic [31:0] first_pos;
	logic [31:0] chain_end_pos;
	logic [31:0] chain_diag;
	logic [31:0] links;
	logic [1:0]  hits_in_group;

	out_item_t frag_expect_q[$];
	out_item_t want;
	int        errors;
	int        matched;

	// Fragment for the open chain, or nothing if the group is small or the span too short
	function automatic bit fragment_of_chain(input logic rev, output out_item_t frag);
		logic [63:0] s, e, k, d, span, ident, qs, qe, se;
		frag = '0;
		if (hits_in_group < 2'd3)
			return 1'b0;
		s = 64'(first_pos);
		e = 64'(chain_end_pos);
		k = 64'(k_len);
		d = 64'(chain_diag);
		if (e + k < s + 64'd1 + 64'(min_span))
			return 1'b0;
		span = e + k - s + 64'd1;
		ident = (64'(links) * k * PERCENT_X100) / span;
		if (ident > 64'd65535)
			ident = 64'd65535;
		// reverse strand mirrors query coordinates by query length
		if (rev) begin
			qs = 64'(qry_len) - (d + s);
			qe = 64'(qry_len) - (d + e) - k + 64'd1;
		end else begin
			qs = d + s + 64'd1;
			qe = d + e + k;
		end
		se = e + k;
		frag.query_start    = qs[31:0];
		frag.query_end      = qe[31:0];
		frag.out_subject_id = prev_subj;
		frag.subject_start  = first_pos + 32'd1;
		frag.subject_end    = se[31:0];
		frag.out_reverse    = rev;
		frag.chain_score    = links;
		frag.identity_x100  = ident[15:0];
		return 1'b1;
	endfunction

	// Advance the chain by one accepted hit, queue the fragment it closes
	task automatic chain_hit(input in_item_t h);
		out_item_t   frag;
		logic        got;
		logic        link;
		logic [31:0] diag;
		got = 1'b0;
		diag = h.diagonal;
		if (!have_prev) begin
			chain_on = 1'b0;
			hits_in_group = 2'd1;
		end else begin
			if (hits_in_group < 2'd3)
				hits_in_group++;
			link = (prev_diag == diag) && (prev_subj == h.subject_id) &&
				(64'(prev_pos) + 64'(link_dist) >= 64'(h.subject_pos));
			if (link) begin
				if (chain_on) begin
					chain_end_pos = h.subject_pos;
					if (links != 32'hFFFF_FFFF)
						links++;
				end else begin
					chain_on = 1'b1;
					chain_diag = prev_diag;
					first_pos = prev_pos;
					chain_end_pos = h.subject_pos;
					links = 32'd1;
				end
			end else if (chain_on) begin
				got = fragment_of_chain(h.reverse_strand, frag);
				chain_on = 1'b0;
			end
		end
		prev_diag = diag;
		prev_subj = h.subject_id;
		prev_pos = h.subject_pos;
		have_prev = 1'b1;
		// group end closes whatever is still open
		if (h.group_last) begin
			if (chain_on && !got)
				got = fragment_of_chain(h.reverse_strand, frag);
			chain_on = 1'b0;
			have_prev = 1'b0;
			hits_in_group = 2'd0;
		end
		if (got)
			frag_expect_q = {frag_expect_q, frag};
	endtask

	function automatic int field_check(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	// Watch the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_len = KMER_LENGTH_RST;
			link_dist = CONNECT_DISTANCE_RST;
			min_span = MIN_FRAGMENT_LENGTH_RST;
			qry_len = QUERY_LENGTH_RST;
			have_prev = 1'b0;
			prev_diag = '0;
			prev_subj = '0;
			prev_pos = '0;
			chain_on = 1'b0;
			first_pos = '0;
			chain_end_pos = '0;
			chain_diag = '0;
			links = '0;
			hits_in_group = '0;
			frag_expect_q.delete();
			errors = 0;
			matched = 0;
			fail_count <= 0;
			pending <= 0;
			frags_checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KMER_LENGTH:         k_len = cfg_data[6:0];
					CFG_CONNECT_DISTANCE:    link_dist = cfg_data[15:0];
					CFG_MIN_FRAGMENT_LENGTH: min_span = cfg_data;
					CFG_QUERY_LENGTH:        qry_len = cfg_data;
					default: ;
				endcase
			end
			// results leave through the back end registers after their hit, so compare first
			if (out_valid && !out_stall) begin
				if (frag_expect_q.size() == 0) begin
					$error("fragment arrived with none expected");
					errors++;
				end else begin
					want = frag_expect_q.pop_front();
					errors += field_check("query_start", want.query_start,
						out_data.query_start);
					errors += field_check("query_end", want.query_end, out_data.query_end);
					errors += field_check("out_subject_id", want.out_subject_id,
						out_data.out_subject_id);
					errors += field_check("subject_start", want.subject_start,
						out_data.subject_start);
					errors += field_check("subject_end", want.subject_end,
						out_data.subject_end);
					errors += field_check("out_reverse", want.out_reverse,
						out_data.out_reverse);
					errors += field_check("chain_score", want.chain_score,
						out_data.chain_score);
					errors += field_check("identity_x100", want.identity_x100,
						out_data.identity_x100);
					matched++;
				end
			end
			if (in_valid && !in_stall)
				chain_hit(in_data);
			fail_count <= errors;
			pending <= frag_expect_q.size();
			frags_checked <= matched;
		end
	end

endmodule

/* sim/tb_diagonal_kmer_hit_chainer.sv */
// Testbench top for the diagonal k-mer hit chainer: stimulus, pacing and verdict.
module tb_diagonal_kmer_hit_chainer
	import dkhc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_PHASES  = 10;
	localparam int PHASE_HITS  = 125;
	localparam int HOLD_PHASE  = 2;
	localparam int RX_HOLD     = 300;
	localparam int SETTLE      = 100;
	localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = CFG_QUERY_LENGTH + 1'b1;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;

	int fail_count;
	int pending;
	int frags_checked;

	int          hits_sent;
	int          groups_sent;
	int          settings_used;
	int          stall_cycles;
	int unsigned cur_link_dist;
	bit          tx_burst;
	bit          hold_req;
	bit          rx_hold_active;

	diagonal_kmer_hit_chainer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dkhc_scoreboard chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.frags_checked (frags_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Idle cycles before the next request: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (tx_burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Offer one hit and hold it until accepted; returns in the accepting step
	task automatic send_hit(input logic [31:0] diag, input logic [15:0] subj,
			input logic [31:0] pos, input logic rev, input logic last);
		in_item_t h;
		int       gap;
		h = '{diagonal: diag, subject_id: subj, subject_pos: pos,
			reverse_strand: rev, group_last: last};
		gap = pick_gap();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= h;
		@(posedge clk);
		while (in_stall) begin
			stall_cycles++;
			@(posedge clk);
		end
		hits_sent++;
	endtask

	// One subject group, mostly linked hits with breaks mixed in
	task automatic send_group(input int forced_n);
		int          n;
		int          r;
		logic [31:0] diag;
		logic [31:0] pos;
		logic [15:0] subj;
		logic        rev;
		r = $urandom_range(0, 99);
		if (forced_n > 0)
			n = forced_n;
		else if (r < 10)
			n = $urandom_range(1, 2);
		else if (r < 85)
			n = $urandom_range(3, 6);
		else
			n = $urandom_range(7, 12);
		diag = $urandom;
		subj = 16'($urandom);
		rev = 1'($urandom);
		pos = $urandom;
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					pos += 32'($urandom_range(0, cur_link_dist));
				else if (r < 72)
					pos += cur_link_dist;
				else if (r < 80)
					pos += cur_link_dist + 32'd1 + 32'($urandom_range(0, 50));
				else if (r < 88) begin
					diag = ($urandom_range(0, 1) != 0) ? diag + 32'd1 : 32'($urandom);
					pos += 32'($urandom_range(0, 20));
				end else if (r < 92)
					subj = 16'($urandom);
				else if (r < 96)
					pos -= 32'($urandom_range(1, 50));
				else
					pos += 32'($urandom_range(0, 3));
			end
			send_hit(diag, subj, pos, rev, i == n - 1);
		end
		groups_sent++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [6:0] k, input logic [15:0] cd,
			input logic [31:0] min_len, input logic [31:0] qlen);
		write_reg(CFG_KMER_LENGTH, 32'(k));
		write_reg(CFG_CONNECT_DISTANCE, 32'(cd));
		write_reg(CFG_MIN_FRAGMENT_LENGTH, min_len);
		write_reg(CFG_QUERY_LENGTH, qlen);
		// an unused index must leave every register alone
		write_reg(4'($urandom_range(FIRST_UNUSED_INDEX, 15)), $urandom);
		cur_link_dist = 32'(cd);
		settings_used++;
	endtask

	// Stop offering until every expected fragment is out and the back end is quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold on request
	initial begin
		int   r;
		int   n;
		logic v;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				rx_hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (RX_HOLD) @(posedge clk);
				rx_hold_active = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					v = 1'b0;
					n = $urandom_range(1, 4);
				end else if (r < 80) begin
					v = 1'b1;
					n = $urandom_range(1, 3);
				end else if (r < 95) begin
					v = 1'b0;
					n = $urandom_range(10, 40);
				end else begin
					v = 1'b1;
					n = $urandom_range(10, 40);
				end
				out_stall <= v;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		int phase_end;
		hits_sent = 0;
		groups_sent = 0;
		settings_used = 1;
		stall_cycles = 0;
		tx_burst = 1'b0;
		hold_req = 1'b0;
		rx_hold_active = 1'b0;
		cur_link_dist = 32'(CONNECT_DISTANCE_RST);
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed hits under the reset settings
		// lone hit, then a linked pair: groups too small to emit
		send_hit(32'd0, 16'd0, 32'd0, 1'b0, 1'b1);
		send_hit(32'd5, 16'd1, 32'd10, 1'b0, 1'b0);
		send_hit(32'd5, 16'd1, 32'd60, 1'b0, 1'b1);
		// three hits on the top diagonal, query coordinates wrap
		send_hit(32'h7FFF_FFFF, 16'hFFFF, 32'd100, 1'b0, 1'b0);
		send_hit(32'h7FFF_FFFF, 16'hFFFF, 32'd200, 1'b0, 1'b0);
		send_hit(32'h7FFF_FFFF, 16'hFFFF, 32'd300, 1'b0, 1'b1);
		// reverse strand near the top of the position range: exact link, break by one
		send_hit(32'h8000_0000, 16'h1234, 32'hFFFF_FF00, 1'b1, 1'b0);
		send_hit(32'h8000_0000, 16'h1234, 32'hFFFF_FF64, 1'b1, 1'b0);
		send_hit(32'h8000_0000, 16'h1234, 32'hFFFF_FFC9, 1'b1, 1'b0);
		send_hit(32'h8000_0000, 16'h1234, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// descending positions link but leave no span
		send_hit(32'd7, 16'd2, 32'd1000, 1'b0, 1'b0);
		send_hit(32'd7, 16'd2, 32'd950, 1'b0, 1'b0);
		send_hit(32'd7, 16'd2, 32'd900, 1'b0, 1'b1);
		// span just short of the minimum
		send_hit(32'd9, 16'd3, 32'd10, 1'b0, 1'b0);
		send_hit(32'd9, 16'd3, 32'd11, 1'b0, 1'b0);
		send_hit(32'd9, 16'd3, 32'd12, 1'b0, 1'b1);
		// diagonal change closes one chain and opens another
		send_hit(32'd3, 16'd4, 32'd0, 1'b0, 1'b0);
		send_hit(32'd3, 16'd4, 32'd50, 1'b0, 1'b0);
		send_hit(32'd4, 16'd4, 32'd60, 1'b0, 1'b0);
		send_hit(32'd4, 16'd4, 32'd100, 1'b0, 1'b1);
		wait_idle();

		// zero k-mer length is taken as is
		set_config(7'd0, 16'd100, 32'd0, 32'd1000);
		send_hit(32'd11, 16'd5, 32'd5, 1'b1, 1'b0);
		send_hit(32'd11, 16'd5, 32'd10, 1'b1, 1'b0);
		send_hit(32'd11, 16'd5, 32'd20, 1'b1, 1'b1);
		wait_idle();

		// Random phases, each under its own settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: set_config(7'd1, 16'd0, 32'd0, 32'hFFFF_FFFF);
				1: set_config(7'd64, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
				HOLD_PHASE: set_config(7'd8, 16'd100, 32'd0, $urandom);
				3: set_config(7'd64, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
				default: set_config(7'($urandom_range(1, 64)),
					($urandom_range(0, 99) < 20) ? 16'($urandom) : 16'($urandom_range(1, 300)),
					($urandom_range(0, 99) < 15) ? 32'($urandom) : 32'($urandom_range(0, 80)),
					$urandom);
			endcase
			phase_end = hits_sent + PHASE_HITS;
			// back-to-back short chains while the receiver holds off
			if (p == HOLD_PHASE) begin
				hold_req = 1'b1;
				wait (rx_hold_active);
				tx_burst = 1'b1;
				repeat (25) send_group(3);
				tx_burst = 1'b0;
			end
			while (hits_sent < phase_end) begin
				if ($urandom_range(0, 99) < 12)
					send_hit($urandom, 16'($urandom), $urandom, 1'($urandom),
						$urandom_range(0, 2) == 0);
				else begin
					tx_burst = ($urandom_range(0, 99) < 20);
					send_group(0);
				end
			end
			tx_burst = 1'b0;
			// close any open group before the settings change
			send_hit($urandom, 16'($urandom), $urandom, 1'($urandom), 1'b1);
			wait_idle();
		end

		$display("Covered %0d hits in %0d groups under %0d register settings;",
			hits_sent, groups_sent, settings_used);
		$display("input held off %0d cycles, %0d fragments compared field by field.",
			stall_cycles, frags_checked);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
